@@ design/mhpf_pkg.sv @@
package mhpf_pkg;

	// Frame control word in its standard bit layout, most significant field first.
	typedef struct packed {
		logic [1:0] src_mode;
		logic [1:0] version;
		logic [1:0] dst_mode;
		logic [1:0] unused_9_8;
		logic       reserved;
		logic       pan_comp;
		logic [1:0] unused_5_4;
		logic       security;
		logic [2:0] frame_type;
	} fc_t;

	typedef logic [1:0] addr_mode_t;

	localparam logic [2:0] FT_DATA      = 3'd1;
	localparam logic [1:0] FC_VERSION_0 = 2'd0;

	localparam addr_mode_t AM_NONE  = 2'd0;
	localparam addr_mode_t AM_RSVD  = 2'd1;
	localparam addr_mode_t AM_SHORT = 2'd2;
	localparam addr_mode_t AM_LONG  = 2'd3;

	localparam logic [15:0] BCAST_ID = 16'hffff;

	// Byte positions of the fixed header fields.
	localparam logic [7:0] POS_FC_LO    = 8'd0;
	localparam logic [7:0] POS_FC_HI    = 8'd1;
	localparam logic [7:0] POS_PAN_LO   = 8'd3;
	localparam logic [7:0] POS_PAN_HI   = 8'd4;
	localparam logic [7:0] POS_SADDR_LO = 8'd5;
	localparam logic [7:0] POS_SADDR_HI = 8'd6;
	localparam logic [7:0] POS_SRC_MIN  = 8'd2;
	localparam logic [7:0] POS_LAST     = 8'd255;

	// Frame control and sequence number bytes.
	localparam logic [4:0] FIXED_HDR_BYTES = 5'd3;
	localparam logic [8:0] NONCE_BYTES     = 9'd4;
	localparam logic [6:0] PAY_MAX         = 7'd127;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} beat_t;

	typedef struct packed {
		logic        status;
		logic        is_broadcast;
		logic        source_is_long;
		logic [63:0] source_mac;
		logic [31:0] nonce_counter;
		logic [4:0]  header_length;
		logic [6:0]  payload_length;
	} result_t;

	function automatic logic [4:0] dest_len(input addr_mode_t mode);
		logic [4:0] r;
		r = 5'd0;
		if (mode == AM_SHORT) r = 5'd4;
		else if (mode == AM_LONG) r = 5'd10;
		return r;
	endfunction

	function automatic logic [4:0] src_len(input addr_mode_t mode, input logic comp);
		logic [4:0] r;
		r = 5'd0;
		if (mode == AM_SHORT) r = comp ? 5'd2 : 5'd4;
		else if (mode == AM_LONG) r = comp ? 5'd8 : 5'd10;
		return r;
	endfunction

endpackage

@@ design/mhpf_in_reg.sv @@
module mhpf_in_reg import mhpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_data,
	input  logic       in_last,
	input  logic       advance,
	output logic       stall,
	output beat_t      beat
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// The register takes a new beat when it is empty or its beat moves on.
	assign stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			data_s1 <= in_data;
			last_s1 <= in_last;
		end
	end

	assign beat = '{valid: valid_s1, data: data_s1, last: last_s1};

endmodule

@@ design/mhpf_parse.sv @@
module mhpf_parse import mhpf_pkg::*; #(
	parameter int MIC_BYTES       = 4,
	parameter int MAX_FRAME_BYTES = 127
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  beat_t       beat,
	input  logic        advance,
	output result_t     result
);

	logic [7:0]  pos_q;
	fc_t         fc_q;
	logic [15:0] pan_q;
	logic [15:0] saddr_q;
	logic [63:0] lsrc_q;
	logic [31:0] tail_q;
	logic        ovl_q;
	logic [15:0] own_pan_q;

	fc_t         fc_n;
	logic [15:0] pan_n;
	logic [15:0] saddr_n;
	logic [63:0] lsrc_n;
	logic [31:0] tail_n;
	logic        ovl_n;
	logic [4:0]  src_off;
	logic        in_src;
	logic [2:0]  lane;
	logic [8:0]  len;
	logic [4:0]  hdr;
	logic [8:0]  need;
	logic [8:0]  pay;
	logic        ok;
	logic        bcast;

	always_comb begin
		fc_n    = fc_q;
		pan_n   = pan_q;
		saddr_n = saddr_q;
		unique case (pos_q)
			POS_FC_LO:    fc_n[7:0]     = beat.data;
			POS_FC_HI:    fc_n[15:8]    = beat.data;
			POS_PAN_LO:   pan_n[7:0]    = beat.data;
			POS_PAN_HI:   pan_n[15:8]   = beat.data;
			POS_SADDR_LO: saddr_n[7:0]  = beat.data;
			POS_SADDR_HI: saddr_n[15:8] = beat.data;
			default: ;
		endcase

		ovl_n = ovl_q || ({1'b0, pos_q} >= 9'(MAX_FRAME_BYTES));

		// The long source address starts after the destination fields and,
		// without compression, the source PAN identifier.
		src_off = FIXED_HDR_BYTES + dest_len(fc_n.dst_mode)
			+ (fc_n.pan_comp ? 5'd0 : 5'd2);
		in_src = (pos_q >= POS_SRC_MIN) && (fc_n.src_mode == AM_LONG)
			&& (pos_q >= {3'b000, src_off}) && (pos_q < ({3'b000, src_off} + 8'd8));
		lane   = 3'(pos_q - {3'b000, src_off});
		lsrc_n = lsrc_q;
		if (in_src) lsrc_n = lsrc_q | (64'(beat.data) << {lane, 3'b000});

		tail_n = {beat.data, tail_q[31:8]};

		len  = {1'b0, pos_q} + 9'd1;
		hdr  = FIXED_HDR_BYTES + dest_len(fc_n.dst_mode)
			+ src_len(fc_n.src_mode, fc_n.pan_comp);
		need = 9'(hdr) + NONCE_BYTES + 9'(MIC_BYTES);
		pay  = len - need;

		ok = !ovl_n && (len >= 9'd2) && (fc_n.frame_type == FT_DATA)
			&& !fc_n.security && !fc_n.reserved && (fc_n.version == FC_VERSION_0)
			&& (fc_n.dst_mode != AM_RSVD) && (fc_n.src_mode != AM_RSVD)
			&& !(fc_n.pan_comp && ((fc_n.dst_mode == AM_NONE) || (fc_n.src_mode == AM_NONE)))
			&& (len >= need);

		bcast = (fc_n.dst_mode == AM_SHORT)
			&& ((pan_n == BCAST_ID) || ((pan_n == own_pan_q) && (saddr_n == BCAST_ID)));

		result = '0;
		if (ok) begin
			result.is_broadcast   = bcast;
			result.source_is_long = (fc_n.src_mode == AM_LONG);
			result.source_mac     = (fc_n.src_mode == AM_LONG) ? lsrc_n : 64'd0;
			result.nonce_counter  = tail_n;
			result.header_length  = hdr;
			result.payload_length = (pay > 9'(PAY_MAX)) ? PAY_MAX : pay[6:0];
		end else begin
			result.status = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_pan_q <= 16'd0;
		end else if (cfg_wr_en) begin
			own_pan_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 8'd0;
			fc_q    <= '0;
			pan_q   <= 16'd0;
			saddr_q <= 16'd0;
			lsrc_q  <= 64'd0;
			tail_q  <= 32'd0;
			ovl_q   <= 1'b0;
		end else if (advance) begin
			if (beat.last) begin
				pos_q   <= 8'd0;
				fc_q    <= '0;
				pan_q   <= 16'd0;
				saddr_q <= 16'd0;
				lsrc_q  <= 64'd0;
				tail_q  <= 32'd0;
				ovl_q   <= 1'b0;
			end else begin
				pos_q   <= (pos_q == POS_LAST) ? pos_q : pos_q + 8'd1;
				fc_q    <= fc_n;
				pan_q   <= pan_n;
				saddr_q <= saddr_n;
				lsrc_q  <= lsrc_n;
				tail_q  <= tail_n;
				ovl_q   <= ovl_n;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && beat.last |=> (pos_q == 8'd0) && !ovl_q && (lsrc_q == 64'd0))
		else $error("frame state not cleared after the last beat");

	a_ovl_pos: assert property (@(posedge clk) disable iff (!arst_n)
		ovl_q |-> ({1'b0, pos_q} >= 9'(MAX_FRAME_BYTES)))
		else $error("overlength flag set below the frame limit");

	a_src_only_long: assert property (@(posedge clk) disable iff (!arst_n)
		(lsrc_q != 64'd0) |-> (fc_q.src_mode == AM_LONG))
		else $error("source address captured for a frame without long source");

endmodule

@@ design/mhpf_out_reg.sv @@
module mhpf_out_reg import mhpf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result,
	input  logic    out_stall,
	output logic    out_valid,
	output logic    free,
	output result_t held
);

	logic    valid_q;
	result_t res_q;

	// A slot is free when empty or when its beat is taken this cycle.
	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= result;
	end

	assign out_valid = valid_q;
	assign held      = res_q;

endmodule

@@ design/mac_header_parser_filter_top.sv @@
// Channel   | Direction | Handshake          | Payload
// input     | in        | in_valid/in_stall  | frame_byte, last_byte
// output    | out       | out_valid/out_stall| status ... payload_length
// config    | in        | cfg_wr_en          | cfg_wr_data (own PAN identifier)
//
// The block accepts a byte in every cycle unless a final byte waits for the output slot.
// A result appears on the output once its last byte has passed the input register:
// the byte is held in the input register, and the parse logic loads the output
// register from it as soon as the output slot is free.
// Reset is asynchronous and active low; it clears the frame state and PAN ID.
// While a result waits under out_stall, non-final bytes keep flowing; only a
// final byte waits in the input register until the output slot frees.
module mac_header_parser_filter_top import mhpf_pkg::*; #(
	parameter int MIC_BYTES       = 4,
	parameter int MAX_FRAME_BYTES = 127
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  frame_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic        is_broadcast,
	output logic        source_is_long,
	output logic [63:0] source_mac,
	output logic [31:0] nonce_counter,
	output logic [4:0]  header_length,
	output logic [6:0]  payload_length
);

	beat_t   beat;
	result_t result;
	result_t held;
	logic    out_free;
	logic    advance;
	logic    load;

	// A byte in the input register moves on at once unless it ends a frame
	// and the output slot is still occupied by an untaken result.
	assign advance = beat.valid && (!beat.last || out_free);
	assign load    = advance && beat.last;

	mhpf_in_reg u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_data (frame_byte),
		.in_last (last_byte),
		.advance (advance),
		.stall   (in_stall),
		.beat    (beat)
	);

	mhpf_parse #(
		.MIC_BYTES      (MIC_BYTES),
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.beat       (beat),
		.advance    (advance),
		.result     (result)
	);

	mhpf_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.result   (result),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.free     (out_free),
		.held     (held)
	);

	assign status         = held.status;
	assign is_broadcast   = held.is_broadcast;
	assign source_is_long = held.source_is_long;
	assign source_mac     = held.source_mac;
	assign nonce_counter  = held.nonce_counter;
	assign header_length  = held.header_length;
	assign payload_length = held.payload_length;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid || !out_stall))
		else $error("result loaded over an untaken result");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !is_broadcast && !source_is_long && (source_mac == 64'd0)
			&& (nonce_counter == 32'd0) && (header_length == 5'd0)
			&& (payload_length == 7'd0))
		else $error("invalid result carries nonzero fields");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid)
		else $error("loaded result not presented");

endmodule

@@ tb/sv/frame_result_checker.sv @@
// Watches the byte and result channels of the MAC header parser, predicts the
// result of each frame from the accepted bytes, and compares the results.
module frame_result_checker import mhpf_pkg::*; #(
	parameter int MIC_BYTES       = 4,
	parameter int MAX_FRAME_BYTES = 127
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  frame_byte,
	input  logic        last_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        status,
	input  logic        is_broadcast,
	input  logic        source_is_long,
	input  logic [63:0] source_mac,
	input  logic [31:0] nonce_counter,
	input  logic [4:0]  header_length,
	input  logic [6:0]  payload_length,
	output int          fail_count,
	output int          pending
);

	logic [15:0] own_pan;
	logic [7:0]  byte_pos;
	logic [15:0] fc_word;
	logic [15:0] dst_pan;
	logic [15:0] dst_short;
	logic [63:0] src_long;
	logic [31:0] last_four;
	logic        too_long;
	result_t     expected_results[$];
	result_t     want;

	function automatic int dst_bytes(input addr_mode_t mode);
		int n;
		n = 0;
		if (mode == AM_SHORT)
			n = 4;
		else if (mode == AM_LONG)
			n = 10;
		return n;
	endfunction

	function automatic int src_bytes(input addr_mode_t mode, input logic comp);
		int n;
		n = 0;
		if (mode == AM_SHORT)
			n = comp ? 2 : 4;
		else if (mode == AM_LONG)
			n = comp ? 8 : 10;
		return n;
	endfunction

	task automatic clear_frame();
		byte_pos  = '0;
		fc_word   = '0;
		dst_pan   = '0;
		dst_short = '0;
		src_long  = '0;
		last_four = '0;
		too_long  = 1'b0;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic is_last);
		int         p;
		int         len;
		int         hdr;
		int         src_off;
		int         pay;
		logic       ok;
		fc_t        f;
		addr_mode_t dm;
		addr_mode_t sm;
		result_t    r;
		p = byte_pos;
		if (p >= MAX_FRAME_BYTES)
			too_long = 1'b1;
		case (p)
			0: fc_word[7:0] = b;
			1: fc_word[15:8] = b;
			3: dst_pan[7:0] = b;
			4: dst_pan[15:8] = b;
			5: dst_short[7:0] = b;
			6: dst_short[15:8] = b;
			default: ;
		endcase
		f = fc_t'(fc_word);
		dm = f.dst_mode;
		sm = f.src_mode;
		src_off = 3 + dst_bytes(dm) + (f.pan_comp ? 0 : 2);
		if (p >= 2 && sm == AM_LONG && p >= src_off && p < src_off + 8)
			src_long = src_long | (64'(b) << (8 * (p - src_off)));
		last_four = {b, last_four[31:8]};
		if (!is_last) begin
			if (p < 255)
				byte_pos = 8'(p + 1);
		end else begin
			len = p + 1;
			hdr = 3 + dst_bytes(dm) + src_bytes(sm, f.pan_comp);
			ok = !too_long && len >= 2 && f.frame_type == FT_DATA && !f.security
				&& !f.reserved && f.version == FC_VERSION_0
				&& dm != AM_RSVD && sm != AM_RSVD
				&& !(f.pan_comp && (dm == AM_NONE || sm == AM_NONE))
				&& len >= hdr + 4 + MIC_BYTES;
			r = '0;
			if (!ok) begin
				r.status = 1'b1;
			end else begin
				pay = len - hdr - 4 - MIC_BYTES;
				r.is_broadcast = dm == AM_SHORT && (dst_pan == BCAST_ID
					|| (dst_pan == own_pan && dst_short == BCAST_ID));
				r.source_is_long = sm == AM_LONG;
				r.source_mac = (sm == AM_LONG) ? src_long : 64'd0;
				r.nonce_counter = last_four;
				r.header_length = 5'(hdr);
				r.payload_length = (pay > 127) ? 7'd127 : 7'(pay);
			end
			expected_results.push_back(r);
			clear_frame();
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			own_pan = '0;
			expected_results.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (cfg_wr_en)
				own_pan = cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat arrived with no frame outstanding");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", 64'(want.status), 64'(status));
					check_field("is_broadcast", 64'(want.is_broadcast),
						64'(is_broadcast));
					check_field("source_is_long", 64'(want.source_is_long),
						64'(source_is_long));
					check_field("source_mac", want.source_mac, source_mac);
					check_field("nonce_counter", 64'(want.nonce_counter),
						64'(nonce_counter));
					check_field("header_length", 64'(want.header_length),
						64'(header_length));
					check_field("payload_length", 64'(want.payload_length),
						64'(payload_length));
				end
			end
			if (in_valid && !in_stall)
				parse_byte(frame_byte, last_byte);
			pending = expected_results.size();
		end
	end

endmodule

@@ tb/sv/tb.sv @@
// Top of the MAC header parser testbench. It builds frames, drives them byte
// by byte into the block, plays the receiver of the result channel, writes
// the PAN register between phases and gives the verdict. All prediction and
// comparison lives in the checker instantiated beside the block.
module tb;
	import mhpf_pkg::*;

	localparam int MIC_BYTES       = 4;
	localparam int MAX_FRAME_BYTES = 127;
	localparam int PHASES          = 8;
	localparam int BYTES_PER_PHASE = 225;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int SETTLE_CYCLES   = 4;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  frame_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic        status;
	logic        is_broadcast;
	logic        source_is_long;
	logic [63:0] source_mac;
	logic [31:0] nonce_counter;
	logic [4:0]  header_length;
	logic [6:0]  payload_length;
	int          fail_count;
	int          pending;

	// Stimulus state: the frame being built, the current PAN value, and the
	// idling percentages of both sides for the running phase.
	logic [7:0]  frame_bytes[$];
	logic [15:0] pan_now;
	int          idle_pct;
	int          stall_pct;
	int          bytes_sent;
	int          hold_req;
	int          hold_seen;
	int          idle_cycles;
	bit          giant_sent;

	mac_header_parser_filter_top #(
		.MIC_BYTES(MIC_BYTES),
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) dut (.*);

	frame_result_checker #(
		.MIC_BYTES(MIC_BYTES),
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The watchdog ends the run when no beat has moved on either channel for
	// far longer than the longest deliberate hold-off.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver. Each falling edge it decides whether to stall the next result
	// beat. When the stimulus asks for a hold-off, it keeps stall high for a
	// long stretch, counting the cycles itself, so that a result parks in the
	// output register and the next final byte backs up the input channel.
	initial begin
		out_stall = 1'b0;
		hold_seen = 0;
		@(negedge clk);
		forever begin
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_stall = ($urandom_range(99) < stall_pct);
				@(negedge clk);
			end
		end
	end

	// Offers one byte beat and returns at the falling edge after it was taken.
	// Valid stays high on return, so the caller either offers the next beat in
	// the same step or lowers valid itself.
	task automatic send_beat(input logic [7:0] b, input logic is_last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		frame_byte = b;
		last_byte = is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_bytes.size(); i++)
			send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	// Builds a well-formed data frame header for the given address modes,
	// followed by the payload and eight trailing bytes for the nonce counter
	// and the MIC. Bits that the parser ignores are left random.
	task automatic build_frame(input addr_mode_t dm, input addr_mode_t sm,
			input logic comp, input int pay_len, input logic [15:0] dpan,
			input logic [15:0] daddr);
		fc_t f;
		f = fc_t'(16'($urandom));
		f.frame_type = FT_DATA;
		f.security = 1'b0;
		f.reserved = 1'b0;
		f.version = FC_VERSION_0;
		f.pan_comp = comp;
		f.dst_mode = dm;
		f.src_mode = sm;
		frame_bytes.delete();
		frame_bytes.push_back(f[7:0]);
		frame_bytes.push_back(f[15:8]);
		frame_bytes.push_back(8'($urandom));
		if (dm != AM_NONE) begin
			frame_bytes.push_back(dpan[7:0]);
			frame_bytes.push_back(dpan[15:8]);
			if (dm == AM_SHORT) begin
				frame_bytes.push_back(daddr[7:0]);
				frame_bytes.push_back(daddr[15:8]);
			end else begin
				repeat (8) frame_bytes.push_back(8'($urandom));
			end
		end
		if (sm != AM_NONE) begin
			if (!comp)
				repeat (2) frame_bytes.push_back(8'($urandom));
			repeat ((sm == AM_LONG) ? 8 : 2) frame_bytes.push_back(8'($urandom));
		end
		repeat (pay_len + 8) frame_bytes.push_back(8'($urandom));
	endtask

	task automatic pad_frame(input int target);
		while (frame_bytes.size() < target)
			frame_bytes.push_back(8'($urandom));
	endtask

	function automatic addr_mode_t pick_mode();
		int r;
		r = $urandom_range(2);
		return (r == 0) ? AM_NONE : ((r == 1) ? AM_SHORT : AM_LONG);
	endfunction

	// Random frame. Most are well formed with random content, steered toward
	// broadcast matches; some sit at or beyond the length limit, some are
	// broken by a flipped frame control bit or truncation, and a few are noise.
	task automatic random_frame();
		int          kind;
		int          cut;
		addr_mode_t  dm;
		addr_mode_t  sm;
		logic        comp;
		logic [15:0] dpan;
		logic [15:0] daddr;
		int          pay;
		kind = $urandom_range(99);
		dm = pick_mode();
		sm = pick_mode();
		comp = (dm != AM_NONE && sm != AM_NONE) ? 1'($urandom_range(1)) : 1'b0;
		case ($urandom_range(3))
			0: dpan = BCAST_ID;
			1: dpan = pan_now;
			default: dpan = 16'($urandom);
		endcase
		daddr = $urandom_range(1) ? BCAST_ID : 16'($urandom);
		pay = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
		if (!giant_sent && idle_pct == 0 && stall_pct == 68) begin
			// A frame far past the limit drives the byte position into saturation.
			giant_sent = 1'b1;
			build_frame(dm, sm, comp, 0, dpan, daddr);
			pad_frame(300);
		end else if (kind < 4) begin
			build_frame(dm, sm, comp, 0, dpan, daddr);
			pad_frame(($urandom_range(1) == 0) ? MAX_FRAME_BYTES
				: MAX_FRAME_BYTES + $urandom_range(1, 8));
		end else if (kind < 78) begin
			build_frame(dm, sm, comp, pay, dpan, daddr);
		end else if (kind < 90) begin
			build_frame(dm, sm, comp, pay, dpan, daddr);
			if ($urandom_range(1) == 0) begin
				frame_bytes[$urandom_range(1)] ^= 8'(1 << $urandom_range(7));
			end else begin
				cut = $urandom_range(1, 9);
				repeat (cut) void'(frame_bytes.pop_back());
			end
		end else begin
			frame_bytes.delete();
			repeat ($urandom_range(1, 24)) frame_bytes.push_back(8'($urandom));
		end
	endtask

	// Lowers valid, waits until every expected result has been delivered, and
	// then lets the two-stage pipeline settle before anything is reconfigured.
	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_pan(input logic [15:0] value);
		cfg_wr_en = 1'b1;
		cfg_wr_data = value;
		pan_now = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		frame_byte = '0;
		last_byte = 1'b0;
		pan_now = '0;
		idle_pct = 0;
		stall_pct = 0;
		bytes_sent = 0;
		hold_req = 0;
		giant_sent = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		for (int phase = 0; phase < PHASES; phase++) begin
			// Each phase after the first runs with a new PAN value: the broadcast
			// value in phases 1 and 5, zero in phase 3, random values in the rest.
			if (phase > 0) begin
				drain();
				case (phase)
					1, 5: write_pan(BCAST_ID);
					3: write_pan(16'h0000);
					default: write_pan(16'($urandom));
				endcase
			end
			case (phase % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 68; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 68; end
				default: begin idle_pct = 16; stall_pct = 16; end
			endcase

			if (phase == 0) begin
				// A frame of one byte, and one that ends with the frame
				// control word: both are too short to be valid.
				frame_bytes = '{8'hff};
				send_frame();
				frame_bytes = '{8'h41, 8'h88};
				send_frame();
				// The shortest valid frame, with neither address present.
				build_frame(AM_NONE, AM_NONE, 1'b0, 0, 16'h0000, 16'h0000);
				send_frame();
				// Short broadcast destination with a compressed source PAN.
				build_frame(AM_SHORT, AM_SHORT, 1'b1, 0, BCAST_ID, BCAST_ID);
				send_frame();
				// The receiver now holds off while bytes keep coming, so the
				// block has to stall its input behind a parked result.
				hold_req++;
			end

			while (bytes_sent < (phase + 1) * BYTES_PER_PHASE) begin
				random_frame();
				send_frame();
			end
		end

		drain();
		repeat (8) @(negedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/mhpf_pkg.sv
design/mhpf_in_reg.sv
design/mhpf_parse.sv
design/mhpf_out_reg.sv
design/mac_header_parser_filter_top.sv
tb/sv/frame_result_checker.sv
tb/sv/tb.sv
